FILE: rtl/bpsm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bpsm_pkg - shared types and constants of the bracket pair matcher
// Bracket kinds, character codes, the stack entry layout and the result
// layout used by the stack memory, the output stage and the top level.
// ============================================================================
package bpsm_pkg;

    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [7:0] CH_PAREN_OPEN  = 8'h28;  // (
    localparam logic [7:0] CH_PAREN_CLOSE = 8'h29;  // )
    localparam logic [7:0] CH_BRACE_OPEN  = 8'h7B;  // {
    localparam logic [7:0] CH_BRACE_CLOSE = 8'h7D;  // }
    localparam logic [7:0] CH_BRACK_OPEN  = 8'h5B;  // [
    localparam logic [7:0] CH_BRACK_CLOSE = 8'h5D;  // ]

    localparam logic [1:0] KIND_PAREN = 2'd0;
    localparam logic [1:0] KIND_BRACE = 2'd1;
    localparam logic [1:0] KIND_BRACK = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Last phase of the six-colour highlight cycle.
    localparam logic [2:0] PHASE_LAST = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] row;
        logic [15:0] col;
        logic [15:0] ordinal;
        logic [2:0]  phase;
    } entry_t;

    typedef struct packed {
        logic        overflowed;
        logic [2:0]  color;
        logic [15:0] pair_number;
        logic [15:0] close_col;
        logic [15:0] close_row;
        logic [15:0] open_col;
        logic [15:0] open_row;
    } result_t;

    function automatic logic [1:0] open_kind(input logic [7:0] c);
        logic [1:0] k;
        k = KIND_NONE;
        unique case (c)
            CH_PAREN_OPEN: k = KIND_PAREN;
            CH_BRACE_OPEN: k = KIND_BRACE;
            CH_BRACK_OPEN: k = KIND_BRACK;
            default:       k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] close_kind(input logic [7:0] c);
        logic [1:0] k;
        k = KIND_NONE;
        unique case (c)
            CH_PAREN_CLOSE: k = KIND_PAREN;
            CH_BRACE_CLOSE: k = KIND_BRACE;
            CH_BRACK_CLOSE: k = KIND_BRACK;
            default:        k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/bpsm_stack_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// bpsm_stack_ram - stack storage below the top entry
// Single write port, single registered read port, with a bypass so that a
// read of the address written in the same cycle returns the new data.
// ============================================================================
module bpsm_stack_ram #(
    parameter int STACK_DEPTH = bpsm_pkg::STACK_DEPTH_DEF,
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  bpsm_pkg::entry_t    wr_data,
    input  logic [AW-1:0]       rd_addr,
    output bpsm_pkg::entry_t    rd_data
);
    import bpsm_pkg::*;

    entry_t mem [STACK_DEPTH];
    entry_t rd_q_reg;
    entry_t byp_data_reg;
    logic   byp_sel_reg;
    logic   byp_sel_next;

    assign byp_sel_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg     <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_sel_reg <= 1'b0;
        end else begin
            byp_sel_reg <= byp_sel_next;
        end
    end

    assign rd_data = byp_sel_reg ? byp_data_reg : rd_q_reg;

endmodule

FILE: rtl/bpsm_out_stage.sv
`timescale 1ns / 1ps
// ============================================================================
// bpsm_out_stage - result register towards the master side
// Holds one pair result until it is taken and accepts a new one in the same
// cycle as the old one leaves.
// ============================================================================
module bpsm_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  bpsm_pkg::result_t   in_data,
    output logic                in_ready,
    output logic                out_valid,
    output bpsm_pkg::result_t   out_data,
    input  logic                out_ready
);
    import bpsm_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/bracket_pair_stream_matcher.sv
`timescale 1ns / 1ps
// ============================================================================
// bracket_pair_stream_matcher - streaming matcher of bracket pairs
// Keeps a stack of open brackets and emits one result for every closing
// bracket that matches the innermost open one.
// ============================================================================
//
//  Channel  | Direction | Carries
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | one text character with its row and column
//  m_axis   | out       | one matched pair: both positions, number, colour
//
// One character is accepted per cycle for as long as the result register can
// take a new result; the top of stack lives in a register and the entry
// beneath it is prefetched from the stack memory every cycle, so a push or a
// pop followed at once by another is handled without a bubble. A result
// appears on m_axis in the cycle after the closing bracket's transfer.
// Reset (aresetn low, synchronous) empties the stack and clears the pair
// counter, colour phase and overflow flag; no memory clearing pass is needed
// because entries above the stack count are never used.
// A stall on m_axis holds s_tready low only while a result is waiting.
//
module bracket_pair_stream_matcher #(
    parameter int STACK_DEPTH = bpsm_pkg::STACK_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata fields from bit 0 up: ch [7:0], row [23:8], col [39:24]
    input  logic [39:0] s_tdata,
    // s_tuser fields: restart [0]
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata fields from bit 0 up: open_row [15:0], open_col [31:16],
    // close_row [47:32], close_col [63:48], pair_number [79:64],
    // color [82:80], overflowed [83], zero padding [87:84]
    output logic [87:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);
    import bpsm_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Input fields.
    logic        in_restart;
    logic [7:0]  in_ch;
    logic [15:0] in_row;
    logic [15:0] in_col;

    assign in_restart = s_tuser;
    assign in_ch      = s_tdata[7:0];
    assign in_row     = s_tdata[23:8];
    assign in_col     = s_tdata[39:24];

    // Stack state: the count and the top entry in registers, the rest in
    // the memory at indices 0 .. count-2.
    logic [CW-1:0] count_reg, count_next;
    logic [15:0]   counter_reg, counter_next;
    logic [2:0]    phase_reg, phase_next;
    logic          flag_reg, flag_next;
    entry_t        top_reg, top_next;

    // Values as seen after an optional restart of this character.
    logic [CW-1:0] eff_count;
    logic [15:0]   eff_counter;
    logic [2:0]    eff_phase;
    logic          eff_flag;

    logic [1:0]    okind;
    logic [1:0]    ckind;
    logic          is_open;
    logic          push_ok;
    logic          pop_ok;
    logic          s_fire;
    entry_t        below;
    entry_t        new_entry;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] count_m1;
    logic [CW-1:0] rd_count;

    result_t       res;
    result_t       out_res;
    logic          res_valid;

    assign s_fire = s_tvalid && s_tready;

    assign eff_count   = in_restart ? '0 : count_reg;
    assign eff_counter = in_restart ? '0 : counter_reg;
    assign eff_phase   = in_restart ? '0 : phase_reg;
    assign eff_flag    = in_restart ? 1'b0 : flag_reg;

    assign okind   = open_kind(in_ch);
    assign ckind   = close_kind(in_ch);
    assign is_open = (okind != KIND_NONE);
    assign push_ok = is_open && (eff_count < CW'(STACK_DEPTH));
    // An opening character never decodes as a closing one, so a close only
    // needs a non-empty stack and a matching kind on top.
    assign pop_ok  = (ckind != KIND_NONE) && (eff_count != '0)
                     && (top_reg.kind == ckind);

    assign new_entry.kind    = okind;
    assign new_entry.row     = in_row;
    assign new_entry.col     = in_col;
    assign new_entry.ordinal = eff_counter;
    assign new_entry.phase   = eff_phase;

    assign count_m1 = eff_count - CW'(1);

    always_comb begin
        count_next   = count_reg;
        counter_next = counter_reg;
        phase_next   = phase_reg;
        flag_next    = flag_reg;
        top_next     = top_reg;
        if (s_fire) begin
            count_next   = eff_count;
            counter_next = eff_counter;
            phase_next   = eff_phase;
            flag_next    = eff_flag;
            if (is_open) begin
                counter_next = eff_counter + 16'd1;
                phase_next   = (eff_phase == PHASE_LAST) ? 3'd0 : eff_phase + 3'd1;
                if (push_ok) begin
                    count_next = eff_count + CW'(1);
                    top_next   = new_entry;
                end else begin
                    flag_next = 1'b1;
                end
            end else if (pop_ok) begin
                count_next = count_m1;
                top_next   = below;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            counter_reg <= '0;
            phase_reg   <= '0;
            flag_reg    <= 1'b0;
        end else begin
            count_reg   <= count_next;
            counter_reg <= counter_next;
            phase_reg   <= phase_next;
            flag_reg    <= flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
    end

    // A push moves the old top into the memory, unless the stack was empty.
    assign wr_en   = s_fire && push_ok && (eff_count != '0);
    assign wr_addr = count_m1[AW-1:0];

    // Prefetch the entry that will lie beneath the top in the next cycle.
    assign rd_count = count_next - CW'(2);
    assign rd_addr  = rd_count[AW-1:0];

    bpsm_stack_ram #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (top_reg),
        .rd_addr (rd_addr),
        .rd_data (below)
    );

    // Pair result for a matched closing bracket.
    assign res.open_row    = top_reg.row;
    assign res.open_col    = top_reg.col;
    assign res.close_row   = in_row;
    assign res.close_col   = in_col;
    assign res.pair_number = top_reg.ordinal;
    assign res.color       = top_reg.phase + 3'd1;
    assign res.overflowed  = eff_flag;

    assign res_valid = s_fire && !is_open && pop_ok;

    bpsm_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {4'd0, out_res};

endmodule
